@@ design/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared beat types and constants for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int CHAN_W    = 8;   // channel width
  localparam int NUM_W     = 16;  // dividend width, holds 255*255 and 150*255
  localparam int DIV_STEPS = 8;   // quotient bits, one per divider stage

  localparam logic [CHAN_W-1:0] HUE_MUL     = 8'd30;   // 60 deg in half-degrees / 1
  localparam logic [CHAN_W-1:0] OFF_RED_NEG = 8'd180;  // wrap past 360 deg
  localparam logic [CHAN_W-1:0] OFF_GREEN   = 8'd60;   // 120 deg
  localparam logic [CHAN_W-1:0] OFF_BLUE    = 8'd120;  // 240 deg
  localparam logic [CHAN_W-1:0] SAT_SCALE   = 8'd255;
  localparam logic [CHAN_W-1:0] HUE_LIMIT   = 8'd180;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_pix_t;

endpackage

@@ design/rgb_to_hsv_pixel.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Pipelined 8-bit RGB to HSV converter, hue in half-degrees (0..179).
// ----------------------------------------------------------------------------
//
//  channel | ports                   | handshake
//  --------+-------------------------+-----------------------------------
//  input   | start, busy, in_pix     | beat taken when start && !busy
//  result  | out_strobe, out_pix     | one-cycle strobe, cannot be held off
//
// A pixel can enter every clock while busy is low. Each result leaves once its
// input beat has passed the input register, min/max stage, numerator stage, then eight
// restoring-divider stages (one quotient bit each) shared in step by the
// hue and saturation lanes; the last divider stage drives the outputs.
// Reset (rst_n low, synchronous) clears all valid bits and holds busy high
// through the reset cycle; busy is low at all other times.
// There is no back-pressure: results stream out in input order.
//
module rgb_to_hsv_pixel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rgbhsv_pkg::rgb_pix_t in_pix,
  output logic                 out_strobe,
  output rgbhsv_pkg::hsv_pix_t out_pix
);
  import rgbhsv_pkg::*;

  typedef enum logic [1:0] {
    SEC_RED_POS,  // red max, green >= blue
    SEC_RED_NEG,  // red max, green < blue
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  localparam int LATENCY = DIV_STEPS + 3;

  // ---------------- input register ----------------
  logic     busy_r;
  logic     in_vld_r;
  rgb_pix_t in_pix_r;
  logic     accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // ---------------- stage A: max, min, sector ----------------
  logic [CHAN_W-1:0] a_hi_nxt, a_lo_nxt, a_d_nxt, a_mag_nxt;
  logic              a_neg_nxt;
  sector_t           a_sec_nxt;

  logic              a_vld_r;
  logic [CHAN_W-1:0] a_hi_r, a_d_r, a_mag_r;
  logic              a_neg_r;
  sector_t           a_sec_r;

  always_comb begin
    a_hi_nxt = in_pix_r.red;
    if (a_hi_nxt < in_pix_r.green) a_hi_nxt = in_pix_r.green;
    if (a_hi_nxt < in_pix_r.blue)  a_hi_nxt = in_pix_r.blue;
    a_lo_nxt = in_pix_r.red;
    if (a_lo_nxt > in_pix_r.green) a_lo_nxt = in_pix_r.green;
    if (a_lo_nxt > in_pix_r.blue)  a_lo_nxt = in_pix_r.blue;
    a_d_nxt = a_hi_nxt - a_lo_nxt;

    // red wins ties first, then green
    if (a_hi_nxt == in_pix_r.red && in_pix_r.green >= in_pix_r.blue) begin
      a_sec_nxt = SEC_RED_POS;
      a_mag_nxt = in_pix_r.green - in_pix_r.blue;
      a_neg_nxt = 1'b0;
    end else if (a_hi_nxt == in_pix_r.red) begin
      a_sec_nxt = SEC_RED_NEG;
      a_mag_nxt = in_pix_r.blue - in_pix_r.green;
      a_neg_nxt = 1'b1;
    end else if (a_hi_nxt == in_pix_r.green) begin
      a_sec_nxt = SEC_GREEN;
      a_neg_nxt = in_pix_r.blue < in_pix_r.red;
      a_mag_nxt = a_neg_nxt ? in_pix_r.red - in_pix_r.blue
                            : in_pix_r.blue - in_pix_r.red;
    end else begin
      a_sec_nxt = SEC_BLUE;
      a_neg_nxt = in_pix_r.red < in_pix_r.green;
      a_mag_nxt = a_neg_nxt ? in_pix_r.green - in_pix_r.red
                            : in_pix_r.red - in_pix_r.green;
    end
  end

  // ---------------- stage B: numerators ----------------
  // hue = off + 30*(+/-mag)/d, folded into one dividend: off*d +/- 30*mag
  logic [CHAN_W-1:0] b_off;
  logic [NUM_W-1:0]  b_base, b_term;

  always_comb begin
    case (a_sec_r)
      SEC_RED_POS: b_off = '0;
      SEC_RED_NEG: b_off = OFF_RED_NEG;
      SEC_GREEN:   b_off = OFF_GREEN;
      SEC_BLUE:    b_off = OFF_BLUE;
      default:     b_off = '0;
    endcase
    b_base = NUM_W'(b_off) * NUM_W'(a_d_r);
    b_term = NUM_W'(HUE_MUL) * NUM_W'(a_mag_r);
  end

  // ---------------- divider lanes ----------------
  // index 0 is loaded by stage B, index s+1 holds the result of step s
  logic              vld_r    [0:DIV_STEPS];
  logic [NUM_W-1:0]  hrem_r   [0:DIV_STEPS];
  logic [CHAN_W-1:0] hdiv_r   [0:DIV_STEPS];
  logic [CHAN_W-1:0] hq_r     [0:DIV_STEPS];
  logic [NUM_W-1:0]  srem_r   [0:DIV_STEPS];
  logic [CHAN_W-1:0] sdiv_r   [0:DIV_STEPS];
  logic [CHAN_W-1:0] sq_r     [0:DIV_STEPS];
  logic [CHAN_W-1:0] bright_r [0:DIV_STEPS];

  logic [NUM_W-1:0]  hrem_nxt   [0:DIV_STEPS];
  logic [CHAN_W-1:0] hdiv_nxt   [0:DIV_STEPS];
  logic [CHAN_W-1:0] hq_nxt     [0:DIV_STEPS];
  logic [NUM_W-1:0]  srem_nxt   [0:DIV_STEPS];
  logic [CHAN_W-1:0] sdiv_nxt   [0:DIV_STEPS];
  logic [CHAN_W-1:0] sq_nxt     [0:DIV_STEPS];
  logic [CHAN_W-1:0] bright_nxt [0:DIV_STEPS];

  logic [NUM_W-1:0]  htrial [0:DIV_STEPS-1];
  logic [NUM_W-1:0]  strial [0:DIV_STEPS-1];

  always_comb begin
    // grey or black: zero dividend over one gives a zero quotient
    if (a_d_r == '0) begin
      hrem_nxt[0] = '0;
      hdiv_nxt[0] = CHAN_W'(1);
    end else begin
      hrem_nxt[0] = a_neg_r ? b_base - b_term : b_base + b_term;
      hdiv_nxt[0] = a_d_r;
    end
    srem_nxt[0]   = NUM_W'(SAT_SCALE) * NUM_W'(a_d_r);
    sdiv_nxt[0]   = (a_hi_r == '0) ? CHAN_W'(1) : a_hi_r;
    hq_nxt[0]     = '0;
    sq_nxt[0]     = '0;
    bright_nxt[0] = a_hi_r;

    // restoring division, MSB first; quotients fit 8 bits by construction
    for (int s = 0; s < DIV_STEPS; s++) begin
      htrial[s] = NUM_W'(hdiv_r[s]) << (DIV_STEPS - 1 - s);
      strial[s] = NUM_W'(sdiv_r[s]) << (DIV_STEPS - 1 - s);
      if (hrem_r[s] >= htrial[s]) begin
        hrem_nxt[s+1] = hrem_r[s] - htrial[s];
        hq_nxt[s+1]   = {hq_r[s][CHAN_W-2:0], 1'b1};
      end else begin
        hrem_nxt[s+1] = hrem_r[s];
        hq_nxt[s+1]   = {hq_r[s][CHAN_W-2:0], 1'b0};
      end
      if (srem_r[s] >= strial[s]) begin
        srem_nxt[s+1] = srem_r[s] - strial[s];
        sq_nxt[s+1]   = {sq_r[s][CHAN_W-2:0], 1'b1};
      end else begin
        srem_nxt[s+1] = srem_r[s];
        sq_nxt[s+1]   = {sq_r[s][CHAN_W-2:0], 1'b0};
      end
      hdiv_nxt[s+1]   = hdiv_r[s];
      sdiv_nxt[s+1]   = sdiv_r[s];
      bright_nxt[s+1] = bright_r[s];
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
      a_vld_r  <= 1'b0;
      for (int s = 0; s <= DIV_STEPS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      busy_r   <= 1'b0;
      in_vld_r <= accept;
      a_vld_r  <= in_vld_r;
      vld_r[0] <= a_vld_r;
      for (int s = 0; s < DIV_STEPS; s++) begin
        vld_r[s+1] <= vld_r[s];
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      in_pix_r <= in_pix;
    end
    a_hi_r  <= a_hi_nxt;
    a_d_r   <= a_d_nxt;
    a_mag_r <= a_mag_nxt;
    a_neg_r <= a_neg_nxt;
    a_sec_r <= a_sec_nxt;
    for (int s = 0; s <= DIV_STEPS; s++) begin
      hrem_r[s]   <= hrem_nxt[s];
      hdiv_r[s]   <= hdiv_nxt[s];
      hq_r[s]     <= hq_nxt[s];
      srem_r[s]   <= srem_nxt[s];
      sdiv_r[s]   <= sdiv_nxt[s];
      sq_r[s]     <= sq_nxt[s];
      bright_r[s] <= bright_nxt[s];
    end
  end

  // ---------------- outputs ----------------
  assign out_strobe         = vld_r[DIV_STEPS];
  assign out_pix.hue        = hq_r[DIV_STEPS];
  assign out_pix.saturation = sq_r[DIV_STEPS];
  assign out_pix.brightness = bright_r[DIV_STEPS];

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("input beat did not come out after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!accept && !busy_r) |-> ##LATENCY !out_strobe)
    else $error("result beat without a matching input beat");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_pix.hue < HUE_LIMIT)
    else $error("hue out of range");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pix.brightness == '0) |->
      (out_pix.saturation == '0 && out_pix.hue == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pix.saturation == '0) |-> out_pix.hue == '0)
    else $error("grey pixel with nonzero hue");

endmodule

@@ tb/sv/rgb_to_hsv_pixel_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_test
// Streams RGB pixels through the converter, with random gaps and a few forced
// drains, and checks every HSV beat against an integer model of the math.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_test;
  import rgbhsv_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  localparam int PIPE_DEPTH   = 11;      // input beat to result strobe
  localparam int RAND_PIXELS  = 950;
  localparam int DRAIN_EVERY  = 200;     // forced drain spacing in random part
  localparam int CYCLE_LIMIT  = 200000;  // ~950 beats * longest gap, times 5

  // One pixel waiting to go out: idle cycles to leave before it, and whether
  // the pipeline must be empty before those idle cycles start.
  typedef struct {
    rgb_pix_t    pix;
    int unsigned gap;
    bit          drain;
  } pix_job_t;

  // HSV beat owed by the block, with the pixel that caused it.
  typedef struct {
    rgb_pix_t src;
    hsv_pix_t hsv;
  } hsv_due_t;

  logic     clk    = 1'b0;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  rgb_pix_t in_pix = '0;
  logic     busy;
  logic     out_strobe;
  hsv_pix_t out_pix;

  pix_job_t    pix_jobs[$];
  hsv_due_t    hsv_due[$];
  int unsigned beats_sent   = 0;  // driver side only
  int unsigned results_seen = 0;  // monitor side, updated with NBA
  int unsigned idle_cnt     = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned err_cnt      = 0;

  rgb_to_hsv_pixel DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pix     (in_pix),
    .out_strobe (out_strobe),
    .out_pix    (out_pix)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Integer HSV model. Hue sector test is red first, then green, then blue, so
  // ties between channels resolve toward red, then green. Every numerator is
  // non-negative, so integer division is a plain floor.
  // --------------------------------------------------------------------------
  function automatic hsv_pix_t hsv_of_pixel(rgb_pix_t p);
    int       r, g, b;
    int       hi, lo, spread, num;
    hsv_pix_t o;
    r  = p.red;
    g  = p.green;
    b  = p.blue;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    spread = hi - lo;

    o.brightness = 8'(hi);
    // black pixel: no saturation
    o.saturation = (hi != 0) ? 8'((255 * spread) / hi) : 8'd0;

    if (spread == 0) begin
      // grey (or black): hue pinned to zero
      o.hue = 8'd0;
    end else begin
      if (hi == r && g >= b) begin
        num = 30 * (g - b);
      end else if (hi == r) begin
        num = 30 * (g - b) + 180 * spread;  // wraps the magenta side
      end else if (hi == g) begin
        num = 30 * (b - r) + 60 * spread;
      end else begin
        num = 30 * (r - g) + 120 * spread;
      end
      if (num < 0) num = 0;
      o.hue = 8'(num / spread);
    end
    return o;
  endfunction

  task automatic log_mismatch(string what);
    err_cnt++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic rgb_pix_t mk_pix(int r, int g, int b);
    rgb_pix_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    return p;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random pixel, biased toward ties, greys and extremes where the sector
  // test and the zero cases live.
  function automatic rgb_pix_t pick_pixel();
    int unsigned roll, v, w;
    rgb_pix_t    p;
    roll = $urandom_range(0, 99);
    p    = rgb_pix_t'($urandom());
    v    = $urandom_range(0, 255);
    w    = $urandom_range(0, 255);
    if (roll < 55) begin
      // fully random
    end else if (roll < 70) begin
      case ($urandom_range(0, 2))
        0:       p.green = p.red;
        1:       p.blue  = p.red;
        default: p.blue  = p.green;
      endcase
    end else if (roll < 78) begin
      p = mk_pix(v, v, v);
    end else if (roll < 90) begin
      // channels pinned to 0 or 255
      p = mk_pix($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                 $urandom_range(0, 1) * 255);
      case ($urandom_range(0, 3))
        0:       p.red   = 8'(v);
        1:       p.green = 8'(v);
        2:       p.blue  = 8'(v);
        default: ;
      endcase
    end else begin
      // narrow spread near some level: small divisors
      p = mk_pix(v, v, v);
      p.red   = 8'((v + $urandom_range(0, 2)) % 256);
      p.green = 8'((v + $urandom_range(0, 2)) % 256);
      p.blue  = 8'((v + $urandom_range(0, 2)) % 256);
      if (w < 64) p.blue = 8'(w);
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one pending job per free slot. A beat is taken on start && !busy;
  // start only moves when the slot is free, and gets one NBA per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pix_job_t job;
    if (!rst_n) begin
      start    <= 1'b0;
      idle_cnt = 0;
    end else if (!start || !busy) begin
      if (start) beats_sent++;
      if (pix_jobs.size() == 0) begin
        start <= 1'b0;
      end else if (pix_jobs[0].drain && results_seen < beats_sent) begin
        // hold off until the pipeline has emptied
        start <= 1'b0;
      end else if (idle_cnt < pix_jobs[0].gap) begin
        idle_cnt++;
        start <= 1'b0;
      end else begin
        job      = pix_jobs.pop_front();
        in_pix   <= job.pix;
        start    <= 1'b1;
        idle_cnt = 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks the result beat against the oldest owed HSV first, then
  // records the input beat taken at the same edge. Results cannot be stalled,
  // so every strobe is a beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    hsv_due_t due;
    if (rst_n) begin
      if (out_strobe !== 1'b0) begin
        if (hsv_due.size() == 0) begin
          log_mismatch($sformatf("result with nothing owed: hue %0d sat %0d val %0d",
                                 out_pix.hue, out_pix.saturation, out_pix.brightness));
        end else begin
          due = hsv_due.pop_front();
          if (out_pix.hue !== due.hsv.hue)
            log_mismatch($sformatf("rgb %0d/%0d/%0d hue %0d, want %0d",
                                   due.src.red, due.src.green, due.src.blue,
                                   out_pix.hue, due.hsv.hue));
          if (out_pix.saturation !== due.hsv.saturation)
            log_mismatch($sformatf("rgb %0d/%0d/%0d saturation %0d, want %0d",
                                   due.src.red, due.src.green, due.src.blue,
                                   out_pix.saturation, due.hsv.saturation));
          if (out_pix.brightness !== due.hsv.brightness)
            log_mismatch($sformatf("rgb %0d/%0d/%0d brightness %0d, want %0d",
                                   due.src.red, due.src.green, due.src.blue,
                                   out_pix.brightness, due.hsv.brightness));
        end
        results_seen <= results_seen + 1;
      end
      if (start && !busy) begin
        due.src = in_pix;
        due.hsv = hsv_of_pixel(in_pix);
        hsv_due.push_back(due);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  task automatic add_pixel(rgb_pix_t p, int unsigned gap, bit drain);
    pix_job_t job;
    job.pix   = p;
    job.gap   = gap;
    job.drain = drain;
    pix_jobs.push_back(job);
  endtask

  initial begin
    rgb_pix_t corners[$];
    int unsigned burst;

    // Directed corners: black, greys, pure primaries and secondaries,
    // channel ties (red wins, then green), the magenta wrap near 180,
    // unit steps off black, near-grey with spread of one.
    corners = '{mk_pix(0, 0, 0),       mk_pix(255, 255, 255), mk_pix(77, 77, 77),
                mk_pix(255, 0, 0),     mk_pix(0, 255, 0),     mk_pix(0, 0, 255),
                mk_pix(255, 255, 0),   mk_pix(0, 255, 255),   mk_pix(255, 0, 255),
                mk_pix(255, 0, 1),     mk_pix(255, 0, 254),   mk_pix(1, 0, 0),
                mk_pix(0, 1, 0),       mk_pix(0, 0, 1),       mk_pix(1, 1, 0),
                mk_pix(255, 254, 254), mk_pix(254, 255, 255), mk_pix(254, 254, 255),
                mk_pix(200, 100, 50),  mk_pix(128, 255, 1),   mk_pix(0, 128, 255),
                mk_pix(170, 85, 170),  mk_pix(1, 255, 0),     mk_pix(0, 1, 255)};
    foreach (corners[i])
      add_pixel(corners[i], (i % 3 == 2) ? 1 : 0, 1'b0);

    // Random stream; bursts of back-to-back beats mixed with gapped ones,
    // and a full drain before the first random pixel and every so often.
    burst = 0;
    for (int i = 0; i < RAND_PIXELS; i++) begin
      if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(16, 48);
      add_pixel(pick_pixel(), (burst != 0) ? 0 : pick_gap(), (i % DRAIN_EVERY) == 0);
      if (burst != 0) burst--;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pix_jobs.size() != 0 || start);
    while (hsv_due.size() != 0) @(negedge clk);
    repeat (2 * PIPE_DEPTH) @(negedge clk);  // catch stray strobes

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
